/* src/mm256_pkg.sv */
// ----------------------------------------------------------------------------
// mm256_pkg
// Shared widths, operation codes and control types of the 256-bit multiplier.
// ----------------------------------------------------------------------------
package mm256_pkg;

    localparam int LIMB_W    = 64;
    localparam int NUM_LIMBS = 4;
    localparam int DIGIT_W   = 32;
    localparam int OPND_W    = LIMB_W * NUM_LIMBS;
    localparam int LANE_W    = OPND_W + LIMB_W;
    localparam int PROD_W    = 2 * OPND_W;
    localparam int OP_W      = 3;

    typedef enum logic [OP_W-1:0] {
        OP_MUL_FULL = 3'd0,
        OP_MUL_LOW  = 3'd1,
        OP_SQR_FULL = 3'd2,
        OP_SQR_LOW  = 3'd3,
        OP_MUL_LIMB = 3'd4
    } op_t;

    typedef struct packed {
        logic low_half;
        logic zero;
    } mode_t;

endpackage

/* src/mm256_in_if.sv */
// ----------------------------------------------------------------------------
// mm256_in_if
// Operand channel: op code and two 256-bit operands as 64-bit limbs.
// ----------------------------------------------------------------------------
interface mm256_in_if import mm256_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [LIMB_W-1:0] a_limb0;
    logic [LIMB_W-1:0] a_limb1;
    logic [LIMB_W-1:0] a_limb2;
    logic [LIMB_W-1:0] a_limb3;
    logic [LIMB_W-1:0] b_limb0;
    logic [LIMB_W-1:0] b_limb1;
    logic [LIMB_W-1:0] b_limb2;
    logic [LIMB_W-1:0] b_limb3;

    modport source (
        output valid, op, a_limb0, a_limb1, a_limb2, a_limb3,
               b_limb0, b_limb1, b_limb2, b_limb3,
        input  ready
    );

    modport sink (
        input  valid, op, a_limb0, a_limb1, a_limb2, a_limb3,
               b_limb0, b_limb1, b_limb2, b_limb3,
        output ready
    );

endinterface

/* src/mm256_out_if.sv */
// ----------------------------------------------------------------------------
// mm256_out_if
// Product channel: 512-bit product as eight 64-bit limbs.
// ----------------------------------------------------------------------------
interface mm256_out_if import mm256_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [LIMB_W-1:0] product_limb0;
    logic [LIMB_W-1:0] product_limb1;
    logic [LIMB_W-1:0] product_limb2;
    logic [LIMB_W-1:0] product_limb3;
    logic [LIMB_W-1:0] product_limb4;
    logic [LIMB_W-1:0] product_limb5;
    logic [LIMB_W-1:0] product_limb6;
    logic [LIMB_W-1:0] product_limb7;

    modport source (
        output valid, product_limb0, product_limb1, product_limb2, product_limb3,
               product_limb4, product_limb5, product_limb6, product_limb7,
        input  ready
    );

    modport sink (
        input  valid, product_limb0, product_limb1, product_limb2, product_limb3,
               product_limb4, product_limb5, product_limb6, product_limb7,
        output ready
    );

endinterface

/* src/mm256_lane.sv */
// ----------------------------------------------------------------------------
// mm256_lane
// One lane: 256-bit operand times one 64-bit limb, three register stages.
// ----------------------------------------------------------------------------
module mm256_lane import mm256_pkg::*; (
    input  logic              clk,
    input  logic              en,
    input  logic [OPND_W-1:0] x,
    input  logic [LIMB_W-1:0] y,
    output logic [LANE_W-1:0] result
);

    localparam int NX   = OPND_W / DIGIT_W;
    localparam int NY   = LIMB_W / DIGIT_W;
    localparam int SUM_W = OPND_W + DIGIT_W;

    logic [2*DIGIT_W-1:0] prod_reg [NY][NX];
    logic [SUM_W-1:0]     half_reg [NY];
    logic [LANE_W-1:0]    result_reg;

    logic [OPND_W-1:0]    even_vec [NY];
    logic [OPND_W-1:0]    odd_vec  [NY];
    logic [SUM_W-1:0]     half_next [NY];
    logic [LANE_W-1:0]    result_next;

    // 32x32 partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < NY; j++)
            begin
                for (int i = 0; i < NX; i++)
                begin
                    prod_reg[j][i] <= {{DIGIT_W{1'b0}}, x[DIGIT_W*i +: DIGIT_W]}
                                    * {{DIGIT_W{1'b0}}, y[DIGIT_W*j +: DIGIT_W]};
                end
            end
        end
    end

    // even and odd digit products do not overlap; add the two rows
    always_comb
    begin
        for (int j = 0; j < NY; j++)
        begin
            for (int k = 0; k < NX / 2; k++)
            begin
                even_vec[j][2*DIGIT_W*k +: 2*DIGIT_W] = prod_reg[j][2*k];
                odd_vec[j][2*DIGIT_W*k +: 2*DIGIT_W]  = prod_reg[j][2*k+1];
            end
            half_next[j] = {{DIGIT_W{1'b0}}, even_vec[j]} + {odd_vec[j], {DIGIT_W{1'b0}}};
        end
        result_next = {{DIGIT_W{1'b0}}, half_reg[0]} + {half_reg[1], {DIGIT_W{1'b0}}};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            half_reg   <= half_next;
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

/* src/mm256_merge.sv */
// ----------------------------------------------------------------------------
// mm256_merge
// Merge four lane results into the 512-bit product and apply the mode mask.
// ----------------------------------------------------------------------------
module mm256_merge import mm256_pkg::*; (
    input  logic              clk,
    input  logic              en,
    input  mode_t             mode,
    input  logic [LANE_W-1:0] lane0,
    input  logic [LANE_W-1:0] lane1,
    input  logic [LANE_W-1:0] lane2,
    input  logic [LANE_W-1:0] lane3,
    output logic [PROD_W-1:0] product
);

    localparam int PAIR_W = LANE_W + LIMB_W;

    logic [PAIR_W-1:0] pair0_reg;
    logic [PAIR_W-1:0] pair1_reg;
    mode_t             mode_reg;
    logic [PROD_W-1:0] product_reg;

    logic [PAIR_W-1:0] pair0_next;
    logic [PAIR_W-1:0] pair1_next;
    logic [PROD_W-1:0] sum;
    logic [PROD_W-1:0] product_next;

    always_comb
    begin
        pair0_next = {{LIMB_W{1'b0}}, lane0} + {lane1, {LIMB_W{1'b0}}};
        pair1_next = {{LIMB_W{1'b0}}, lane2} + {lane3, {LIMB_W{1'b0}}};
        sum = {{(PROD_W-PAIR_W){1'b0}}, pair0_reg}
            + {pair1_reg[PROD_W-2*LIMB_W-1:0], {(2*LIMB_W){1'b0}}};
        product_next = sum;
        if (mode_reg.low_half)
        begin
            product_next[PROD_W-1:OPND_W] = '0;
        end
        if (mode_reg.zero)
        begin
            product_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pair0_reg   <= pair0_next;
            pair1_reg   <= pair1_next;
            mode_reg    <= mode;
            product_reg <= product_next;
        end
    end

    assign product = product_reg;

endmodule

/* src/multimode_256bit_multiplier.sv */
// ----------------------------------------------------------------------------
// multimode_256bit_multiplier
// Every accepted item runs through the lane stages and the merge stages.
// Throughput: one item per cycle; four 64-bit lanes of 32x32 multipliers
// plus a two-stage merge adder tree, all advancing together.
// An output stall holds the whole pipeline and drops in_ch.ready.
// Reset clears the stage valid bits only; datapath registers have no reset.
// ----------------------------------------------------------------------------
module multimode_256bit_multiplier import mm256_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    mm256_in_if.sink    in_ch,
    mm256_out_if.source out_ch
);

    localparam int LANE_STAGES = 3;
    localparam int STAGES      = LANE_STAGES + 2;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    mode_t             mode_reg [LANE_STAGES];

    logic              adv;
    mode_t             mode_in;
    logic [OPND_W-1:0] x;
    logic [LIMB_W-1:0] y_limb [NUM_LIMBS];
    logic [LANE_W-1:0] lane_res [NUM_LIMBS];
    logic [PROD_W-1:0] product;

    assign adv         = !valid_reg[STAGES-1] || out_ch.ready;
    assign in_ch.ready = adv;

    assign x = {in_ch.a_limb3, in_ch.a_limb2, in_ch.a_limb1, in_ch.a_limb0};

    // decode op and choose the multiplier limbs
    always_comb
    begin
        mode_in   = '0;
        y_limb[0] = in_ch.b_limb0;
        y_limb[1] = in_ch.b_limb1;
        y_limb[2] = in_ch.b_limb2;
        y_limb[3] = in_ch.b_limb3;
        unique case (in_ch.op)
            OP_MUL_FULL:
            begin
            end
            OP_MUL_LOW:
            begin
                mode_in.low_half = 1'b1;
            end
            OP_SQR_FULL, OP_SQR_LOW:
            begin
                mode_in.low_half = (in_ch.op == OP_SQR_LOW);
                y_limb[0] = in_ch.a_limb0;
                y_limb[1] = in_ch.a_limb1;
                y_limb[2] = in_ch.a_limb2;
                y_limb[3] = in_ch.a_limb3;
            end
            OP_MUL_LIMB:
            begin
                y_limb[1] = '0;
                y_limb[2] = '0;
                y_limb[3] = '0;
            end
            default:
            begin
                mode_in.zero = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        valid_next = {valid_reg[STAGES-2:0], in_ch.valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    // carry the mode alongside the lane stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mode_reg[0] <= mode_in;
            for (int s = 1; s < LANE_STAGES; s++)
            begin
                mode_reg[s] <= mode_reg[s-1];
            end
        end
    end

    for (genvar k = 0; k < NUM_LIMBS; k++)
    begin : g_lane
        mm256_lane u_lane (
            .clk    (clk),
            .en     (adv),
            .x      (x),
            .y      (y_limb[k]),
            .result (lane_res[k])
        );
    end

    mm256_merge u_merge (
        .clk     (clk),
        .en      (adv),
        .mode    (mode_reg[LANE_STAGES-1]),
        .lane0   (lane_res[0]),
        .lane1   (lane_res[1]),
        .lane2   (lane_res[2]),
        .lane3   (lane_res[3]),
        .product (product)
    );

    assign out_ch.valid         = valid_reg[STAGES-1];
    assign out_ch.product_limb0 = product[0*LIMB_W +: LIMB_W];
    assign out_ch.product_limb1 = product[1*LIMB_W +: LIMB_W];
    assign out_ch.product_limb2 = product[2*LIMB_W +: LIMB_W];
    assign out_ch.product_limb3 = product[3*LIMB_W +: LIMB_W];
    assign out_ch.product_limb4 = product[4*LIMB_W +: LIMB_W];
    assign out_ch.product_limb5 = product[5*LIMB_W +: LIMB_W];
    assign out_ch.product_limb6 = product[6*LIMB_W +: LIMB_W];
    assign out_ch.product_limb7 = product[7*LIMB_W +: LIMB_W];

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |-> !in_ch.ready)
        else $error("input taken while product stalled");

    a_accept_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> valid_reg[0])
        else $error("accepted item missing from first stage");

    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(valid_reg))
        else $error("pipeline moved during stall");

    a_drain_to_output: assert property (@(posedge clk) disable iff (!rst_n)
        adv && valid_reg[STAGES-2] |=> out_ch.valid)
        else $error("item lost before output stage");

endmodule
